// ===== rtl/first_fit_heap_allocator_macros.svh =====
// Assertion macros for the first-fit heap allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Clocked implication with the reset disable.
`define FFHA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Clocked implication with the consequent checked in the next cycle.
`define FFHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
// Package: types, status codes and command codes of the heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
    localparam int ADDR_W = 32;
    localparam int BYTES_W = 24;
    localparam int STATUS_W = 2;
    localparam logic [ADDR_W-1:0] ALIGN_MASK = 32'h0000_000F;
    localparam logic [ADDR_W-1:0] SPLIT_EXTRA = 32'd16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_OOM       = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_REQ,
        S_SCAN_WAIT,
        S_SCAN_EVAL,
        S_SHIFT_RD,
        S_SHIFT_WAIT,
        S_SHIFT_WR,
        S_FREE_NXT,
        S_FREE_NXT_W,
        S_FREE_PRV,
        S_FREE_PRV_W,
        S_DONE
    } state_t;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_RD_SCAN,
        OP_SCAN_STEP,
        OP_TAKE,
        OP_APPEND,
        OP_OOM,
        OP_NOTFOUND,
        OP_IGNORE,
        OP_SH_RD,
        OP_SH_WR,
        OP_FREE_MARK,
        OP_RD_NXT,
        OP_MERGE_NXT,
        OP_RD_PRV,
        OP_MERGE_PRV
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ignore;
        logic is_free_cmd;
        logic scan_end;
        logic hit;
        logic full;
        logic fits_limit;
        logic need_split;
        logic shift_done;
        logic shift_up;
        logic nxt_ok;
        logic prv_ok;
    } ctrl_sts_t;
endpackage

// ===== rtl/ffha_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module ffha_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/ffha_datapath.sv =====
// Datapath: block table memory, scan address, shift engine and result registers.
`timescale 1ns / 1ps
module ffha_datapath #(
    parameter int MAX_BLOCKS = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffha_pkg::ctrl_cmd_t           cmd,
    output ffha_pkg::ctrl_sts_t           sts,
    input  logic                          in_fire,
    input  logic                          in_command,
    input  logic [ffha_pkg::BYTES_W-1:0]  in_byte_count,
    input  logic [ffha_pkg::ADDR_W-1:0]   in_free_address,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]   cfg_wdata,
    output logic [ffha_pkg::ADDR_W-1:0]   res_address,
    output ffha_pkg::status_t             res_status
);
    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
    localparam logic [33:0] HDR = 34'(HEADER_BYTES);

    logic [ADDR_W-1:0] base_reg, limit_reg, end_reg, end_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     sh_reg, sh_next;
    logic [33:0]       hdr_reg, hdr_next;
    logic              cmd_reg;
    logic [ADDR_W-1:0] want_reg, addr_reg;
    logic [ADDR_W-1:0] ins_size_reg, ins_size_next;
    logic              ins_free_reg, ins_free_next;
    logic [ADDR_W-1:0] cur_size_reg, cur_size_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    status_t           res_st_reg, res_st_next;
    logic              we;
    logic [IW-1:0]     waddr, raddr;
    logic [ADDR_W:0]   wdata, rdata;
    logic [ADDR_W-1:0] rsz;
    logic              rfree;
    logic [33:0]       base_sel, new_end;
    logic [ADDR_W-1:0] want_c;

    assign rsz = rdata[ADDR_W-1:0];
    assign rfree = rdata[ADDR_W];
    assign want_c = (32'(in_byte_count) + ALIGN_MASK) & ~ALIGN_MASK;
    assign base_sel = (cnt_reg == '0) ? 34'(base_reg) : 34'(end_reg);
    assign new_end = base_sel + HDR + 34'(want_reg);

    ffha_ram #(.WIDTH(ADDR_W + 1), .DEPTH(MAX_BLOCKS)) u_tbl (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb begin
        sts.ignore      = cmd_reg ? (addr_reg == '0) : (want_reg == '0);
        sts.is_free_cmd = cmd_reg;
        sts.scan_end    = (idx_reg >= cnt_reg);
        sts.hit         = cmd_reg ? (hdr_reg + HDR == 34'(addr_reg))
                                  : (rfree && rsz >= want_reg);
        sts.full        = (cnt_reg >= MAXC);
        sts.fits_limit  = (new_end <= 34'(limit_reg));
        sts.need_split  = (34'(rsz) >= 34'(want_reg) + HDR + 34'(SPLIT_EXTRA))
                          && (cnt_reg < MAXC);
        sts.shift_up    = ins_free_reg;
        sts.shift_done  = ins_free_reg ? (sh_reg <= idx_reg + CW'(1))
                                       : (sh_reg + CW'(1) >= cnt_reg);
        sts.nxt_ok      = (idx_reg + CW'(1) < cnt_reg) && rfree;
        sts.prv_ok      = (idx_reg != '0) && rfree;
    end

    always_comb begin
        we = 1'b0;
        waddr = idx_reg[IW-1:0];
        wdata = {1'b0, cur_size_reg};
        raddr = idx_reg[IW-1:0];
        idx_next = idx_reg;
        hdr_next = hdr_reg;
        cnt_next = cnt_reg;
        end_next = end_reg;
        sh_next = sh_reg;
        ins_size_next = ins_size_reg;
        ins_free_next = ins_free_reg;
        cur_size_next = cur_size_reg;
        res_addr_next = res_addr_reg;
        res_st_next = res_st_reg;
        unique case (cmd.op)
            OP_START: begin
                idx_next = '0;
                hdr_next = 34'(base_reg);
            end
            OP_RD_SCAN: raddr = idx_reg[IW-1:0];
            OP_SCAN_STEP: begin
                idx_next = idx_reg + CW'(1);
                hdr_next = hdr_reg + HDR + 34'(rsz);
            end
            OP_TAKE: begin
                we = 1'b1;
                res_addr_next = 32'(hdr_reg + HDR);
                res_st_next = ST_OK;
                if (sts.need_split) begin
                    wdata = {1'b0, want_reg};
                    ins_size_next = rsz - want_reg - 32'(HEADER_BYTES);
                    ins_free_next = 1'b1;
                    sh_next = cnt_reg;
                    cnt_next = cnt_reg + CW'(1);
                end else begin
                    wdata = {1'b0, rsz};
                    ins_free_next = 1'b0;
                    sh_next = '0;
                end
            end
            OP_APPEND: begin
                we = 1'b1;
                waddr = cnt_reg[IW-1:0];
                wdata = {1'b0, want_reg};
                cnt_next = cnt_reg + CW'(1);
                end_next = new_end[ADDR_W-1:0];
                res_addr_next = 32'(base_sel + HDR);
                res_st_next = ST_OK;
            end
            OP_OOM: begin
                res_addr_next = '0;
                res_st_next = ST_OOM;
            end
            OP_NOTFOUND: begin
                res_addr_next = '0;
                res_st_next = ST_NOT_FOUND;
            end
            OP_IGNORE: begin
                res_addr_next = '0;
                res_st_next = ST_IGNORED;
            end
            OP_SH_RD: begin
                raddr = ins_free_reg ? IW'(sh_reg - CW'(1)) : IW'(sh_reg + CW'(1));
            end
            OP_SH_WR: begin
                we = 1'b1;
                if (ins_free_reg) begin
                    if (sh_reg == idx_reg + CW'(1)) begin
                        waddr = sh_reg[IW-1:0];
                        wdata = {1'b1, ins_size_reg};
                    end else begin
                        waddr = sh_reg[IW-1:0];
                        wdata = rdata;
                        sh_next = sh_reg - CW'(1);
                    end
                end else begin
                    if (sh_reg + CW'(1) >= cnt_reg) begin
                        we = 1'b0;
                        cnt_next = cnt_reg - CW'(1);
                    end else begin
                        waddr = sh_reg[IW-1:0];
                        wdata = rdata;
                        sh_next = sh_reg + CW'(1);
                    end
                end
            end
            OP_FREE_MARK: begin
                we = 1'b1;
                wdata = {1'b1, rsz};
                cur_size_next = rsz;
                res_addr_next = '0;
                res_st_next = ST_OK;
                raddr = IW'(idx_reg + CW'(1));
            end
            OP_RD_NXT: raddr = IW'(idx_reg + CW'(1));
            OP_MERGE_NXT: begin
                we = 1'b1;
                cur_size_next = cur_size_reg + 32'(HEADER_BYTES) + rsz;
                wdata = {1'b1, cur_size_next};
                ins_free_next = 1'b0;
                sh_next = idx_reg + CW'(1);
            end
            OP_RD_PRV: raddr = IW'(idx_reg - CW'(1));
            OP_MERGE_PRV: begin
                we = 1'b1;
                waddr = IW'(idx_reg - CW'(1));
                wdata = {1'b1, rsz + 32'(HEADER_BYTES) + cur_size_reg};
                ins_free_next = 1'b0;
                sh_next = idx_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            limit_reg <= '1;
            end_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cfg_we && !cfg_index) base_reg <= cfg_wdata;
            if (cfg_we && cfg_index) limit_reg <= cfg_wdata;
            end_reg <= end_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg <= in_command;
            want_reg <= want_c;
            addr_reg <= in_free_address;
        end
        idx_reg <= idx_next;
        hdr_reg <= hdr_next;
        sh_reg <= sh_next;
        ins_size_reg <= ins_size_next;
        ins_free_reg <= ins_free_next;
        cur_size_reg <= cur_size_next;
        res_addr_reg <= res_addr_next;
        res_st_reg <= res_st_next;
    end

    assign res_address = res_addr_reg;
    assign res_status = res_st_reg;
endmodule

// ===== rtl/ffha_ctrl.sv =====
// Controller: sequences scan, take, append, split shift and free merges.
`timescale 1ns / 1ps
module ffha_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_fire,
    input  logic                m_fire,
    input  ffha_pkg::ctrl_sts_t sts,
    output ffha_pkg::ctrl_cmd_t cmd,
    output logic                busy,
    output logic                out_valid
);
    import ffha_pkg::*;

    state_t state_reg, state_next;
    logic   merge_prv_reg, merge_prv_next;

    always_comb begin
        state_next = state_reg;
        merge_prv_next = merge_prv_reg;
        unique case (state_reg)
            S_IDLE: if (s_fire) state_next = S_SCAN_REQ;
            S_SCAN_REQ: begin
                if (sts.ignore) state_next = S_DONE;
                else if (sts.scan_end) state_next = S_DONE;
                else if (sts.is_free_cmd && sts.hit) state_next = S_SCAN_WAIT;
                else state_next = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: state_next = S_SCAN_EVAL;
            S_SCAN_EVAL: begin
                if (sts.is_free_cmd) begin
                    if (sts.hit) state_next = S_FREE_NXT;
                    else state_next = S_SCAN_REQ;
                end else if (sts.hit) begin
                    state_next = sts.need_split ? S_SHIFT_RD : S_DONE;
                end else begin
                    state_next = S_SCAN_REQ;
                end
                merge_prv_next = 1'b0;
            end
            S_SHIFT_RD: state_next = sts.shift_done ? S_SHIFT_WR : S_SHIFT_WAIT;
            S_SHIFT_WAIT: state_next = S_SHIFT_WR;
            S_SHIFT_WR: begin
                if (sts.shift_done) state_next = merge_prv_reg ? S_DONE : 
                                   (sts.is_free_cmd ? S_FREE_PRV : S_DONE);
                else state_next = S_SHIFT_RD;
            end
            S_FREE_NXT: state_next = S_FREE_NXT_W;
            S_FREE_NXT_W: state_next = sts.nxt_ok ? S_SHIFT_RD : S_FREE_PRV;
            S_FREE_PRV: state_next = S_FREE_PRV_W;
            S_FREE_PRV_W: begin
                if (sts.prv_ok) begin
                    state_next = S_SHIFT_RD;
                    merge_prv_next = 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: if (m_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE: if (s_fire) cmd.op = OP_START;
            S_SCAN_REQ: begin
                if (sts.ignore) cmd.op = OP_IGNORE;
                else if (sts.scan_end) begin
                    if (sts.is_free_cmd) cmd.op = OP_NOTFOUND;
                    else if (sts.full || !sts.fits_limit) cmd.op = OP_OOM;
                    else cmd.op = OP_APPEND;
                end else cmd.op = OP_RD_SCAN;
            end
            S_SCAN_EVAL: begin
                if (sts.hit) cmd.op = sts.is_free_cmd ? OP_NONE : OP_TAKE;
                else cmd.op = OP_SCAN_STEP;
            end
            S_SHIFT_RD: cmd.op = OP_SH_RD;
            S_SHIFT_WAIT: cmd.op = OP_SH_RD;
            S_SHIFT_WR: cmd.op = OP_SH_WR;
            S_FREE_NXT: cmd.op = OP_FREE_MARK;
            S_FREE_NXT_W: if (sts.nxt_ok) cmd.op = OP_MERGE_NXT;
            S_FREE_PRV: cmd.op = OP_RD_PRV;
            S_FREE_PRV_W: if (sts.prv_ok) cmd.op = OP_MERGE_PRV;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            merge_prv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            merge_prv_reg <= merge_prv_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator with split and coalesce.
//  channel | direction | contents
//  s_axis  | in        | tdata: command, byte_count, free_address
//  m_axis  | out       | tdata: payload_address, status
//  cfg     | in        | cfg_we, cfg_index, cfg_wdata (heap_base, heap_limit)
// One request at a time; each request walks table entries through the
// single-read table RAM, and a split or merge moves entries one by one.
// Synchronous active-low reset empties the table at once. A result holds
// on m_axis until taken.
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[0], byte_count[24:1], free_address[56:25], zero pad[63:57]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // payload_address[31:0], status[33:32], zero pad[39:34]
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);
    import ffha_pkg::*;

    ctrl_cmd_t         cmd;
    ctrl_sts_t         sts;
    logic              busy, s_fire, m_fire;
    logic [ADDR_W-1:0] res_address;
    status_t           res_status;

    assign s_axis_tready = !busy;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {6'b0, res_status, res_address};

    ffha_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_fire(s_fire), .m_fire(m_fire),
        .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
    );

    ffha_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_fire(s_fire), .in_command(s_axis_tdata[0]),
        .in_byte_count(s_axis_tdata[24:1]), .in_free_address(s_axis_tdata[56:25]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .res_address(res_address), .res_status(res_status)
    );
endmodule

// ===== rtl/ffha_checker.sv =====
// Port-level checker for the heap allocator, bound to the top level.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_macros.svh"
module ffha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    import ffha_pkg::*;

    `FFHA_ASSERT_IMPL(a_no_in_while_out, aclk, aresetn, m_axis_tvalid,
        !s_axis_tready, "input taken while result pending")
    `FFHA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    `FFHA_ASSERT_IMPL(a_fail_zero, aclk, aresetn,
        m_axis_tvalid && m_axis_tdata[33:32] != ST_OK,
        m_axis_tdata[31:0] == 32'd0, "failed result carries an address")
    `FFHA_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second transfer before result")
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== dv/ffha_tb_pkg.sv =====
// Testbench package: register indexes of the heap allocator's write port.
`timescale 1ns / 1ps
package ffha_tb_pkg;
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;
endpackage

// ===== dv/heap_scoreboard.sv =====
// Scoreboard: tracks the block table, predicts allocator responses and compares them.
`timescale 1ns / 1ps
module heap_scoreboard #(
    parameter int MAX_BLOCKS = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          errors,
    output int          pending
);
    import ffha_pkg::*;
    import ffha_tb_pkg::*;

    typedef struct {
        logic [31:0] addr;
        status_t     st;
    } reply_t;

    reply_t      replies_due[$];
    logic [31:0] blk_size [MAX_BLOCKS];
    logic        blk_free [MAX_BLOCKS];
    int          blk_cnt;
    logic [31:0] heap_top;
    logic [31:0] base_reg;
    logic [31:0] limit_reg;

    function automatic void table_insert(int idx, logic [31:0] sz, logic fr);
        for (int k = blk_cnt; k > idx; k--) begin
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
        end
        blk_size[idx] = sz;
        blk_free[idx] = fr;
        blk_cnt++;
    endfunction

    function automatic void table_remove(int idx);
        for (int k = idx; k + 1 < blk_cnt; k++) begin
            blk_size[k] = blk_size[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_cnt--;
    endfunction

    function automatic reply_t heap_response(logic cmd, logic [23:0] nbytes,
                                             logic [31:0] faddr);
        reply_t      r;
        logic [31:0] want;
        logic [63:0] hdr;
        logic [63:0] start;
        logic [63:0] top;
        int          idx;
        r.addr = '0;
        r.st = ST_OK;
        hdr = {32'b0, base_reg};
        idx = -1;
        if (cmd == CMD_ALLOC) begin
            if (nbytes == '0) begin
                r.st = ST_IGNORED;
                return r;
            end
            want = ({8'b0, nbytes} + 32'd15) & ~32'd15;
            for (int i = 0; i < blk_cnt && idx < 0; i++) begin
                if (blk_free[i] && blk_size[i] >= want) idx = i;
                else hdr += 64'(HEADER_BYTES) + 64'(blk_size[i]);
            end
            if (idx >= 0) begin
                blk_free[idx] = 1'b0;
                if (64'(blk_size[idx]) >= 64'(want) + 64'(HEADER_BYTES) + 64'd16
                        && blk_cnt < MAX_BLOCKS) begin
                    table_insert(idx + 1, blk_size[idx] - want - 32'(HEADER_BYTES), 1'b1);
                    blk_size[idx] = want;
                end
                r.addr = 32'(hdr + 64'(HEADER_BYTES));
                return r;
            end
            if (blk_cnt >= MAX_BLOCKS) begin
                r.st = ST_OOM;
                return r;
            end
            start = (blk_cnt == 0) ? {32'b0, base_reg} : {32'b0, heap_top};
            top = start + 64'(HEADER_BYTES) + 64'(want);
            if (top > {32'b0, limit_reg}) begin
                r.st = ST_OOM;
                return r;
            end
            table_insert(blk_cnt, want, 1'b0);
            heap_top = top[31:0];
            r.addr = 32'(start + 64'(HEADER_BYTES));
            return r;
        end
        if (faddr == '0) begin
            r.st = ST_IGNORED;
            return r;
        end
        for (int i = 0; i < blk_cnt && idx < 0; i++) begin
            if (hdr + 64'(HEADER_BYTES) == {32'b0, faddr}) idx = i;
            else hdr += 64'(HEADER_BYTES) + 64'(blk_size[i]);
        end
        if (idx < 0) begin
            r.st = ST_NOT_FOUND;
            return r;
        end
        blk_free[idx] = 1'b1;
        if (idx + 1 < blk_cnt && blk_free[idx+1]) begin
            blk_size[idx] += 32'(HEADER_BYTES) + blk_size[idx+1];
            table_remove(idx + 1);
        end
        if (idx > 0 && blk_free[idx-1]) begin
            blk_size[idx-1] += 32'(HEADER_BYTES) + blk_size[idx];
            table_remove(idx);
        end
        return r;
    endfunction

    assign pending = replies_due.size();

    always @(posedge aclk) begin
        reply_t due;
        if (!aresetn) begin
            replies_due.delete();
            blk_cnt = 0;
            heap_top = '0;
            base_reg = '0;
            limit_reg = '1;
            errors <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_HEAP_BASE) base_reg = cfg_wdata;
                else limit_reg = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(heap_response(s_axis_tdata[0], s_axis_tdata[24:1],
                                                    s_axis_tdata[56:25]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (replies_due.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected response addr=%h status=%0d",
                                 m_axis_tdata[31:0], m_axis_tdata[33:32]);
                    errors <= errors + 1;
                end else begin
                    due = replies_due.pop_front();
                    if (m_axis_tdata[31:0] !== due.addr || m_axis_tdata[33:32] !== due.st) begin
                        if (errors < 10)
                            $display({"mismatch: expected addr=%h status=%0d,",
                                      " got addr=%h status=%0d"},
                                     due.addr, due.st, m_axis_tdata[31:0],
                                     m_axis_tdata[33:32]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb.sv =====
// Testbench top: drives requests and register writes into the heap allocator and reports the verdict.
`timescale 1ns / 1ps
module tb;
    import ffha_pkg::*;
    import ffha_tb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    int          errors;
    int          pending;
    logic        calm;
    int          stall_left;
    logic [31:0] live_addrs[$];

    first_fit_heap_allocator dut (.*);

    heap_scoreboard sb (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // Hold a random stall on the result side; collect granted addresses.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && m_axis_tdata[33:32] == ST_OK
                    && m_axis_tdata[31:0] != '0) begin
                live_addrs.push_back(m_axis_tdata[31:0]);
                if (live_addrs.size() > 200) void'(live_addrs.pop_front());
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) stall_left <= gap_len();
            end
        end
    end

    task automatic send(logic cmd, logic [23:0] nbytes, logic [31:0] faddr);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, faddr, nbytes, cmd};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_request(int alloc_pct);
        int          p;
        logic [31:0] a;
        p = $urandom_range(0, 99);
        if (p < alloc_pct) begin
            p = $urandom_range(0, 99);
            if (p < 70) send(CMD_ALLOC, 24'($urandom_range(1, 128)), $urandom);
            else if (p < 90) send(CMD_ALLOC, 24'($urandom_range(129, 4096)), $urandom);
            else if (p < 95) send(CMD_ALLOC, 24'($urandom), $urandom);
            else send(CMD_ALLOC, '0, $urandom);
        end else begin
            p = $urandom_range(0, 99);
            a = $urandom;
            if (live_addrs.size() > 0 && p < 85) begin
                a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                if (p >= 75) a = a + 32'($urandom_range(1, 48)) - 32'd24;
            end else if (p >= 95) begin
                a = '0;
            end
            send(CMD_FREE, 24'($urandom), a);
        end
    endtask

    initial begin
        logic [31:0] bval;
        logic [31:0] lval;
        int          q;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_HEAP_BASE;
        cfg_wdata = '0;
        calm = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_HEAP_BASE, 32'd0);
        write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        send(CMD_ALLOC, 24'd0, 32'hFFFF_FFFF);
        send(CMD_FREE, 24'hFF_FFFF, 32'd0);
        send(CMD_FREE, 24'd0, 32'd12345);
        send(CMD_ALLOC, 24'd1, 32'd0);
        send(CMD_ALLOC, 24'd16, 32'd0);
        send(CMD_ALLOC, 24'd17, 32'd0);
        send(CMD_ALLOC, 24'd200, 32'd0);
        send(CMD_FREE, 24'd0, 32'd32);
        send(CMD_FREE, 24'd0, 32'd32);
        send(CMD_ALLOC, 24'd8, 32'd0);
        send(CMD_FREE, 24'd0, 32'd192);
        send(CMD_ALLOC, 24'd16, 32'd0);
        send(CMD_ALLOC, 24'd100, 32'd0);
        send(CMD_FREE, 24'd0, 32'd80);
        send(CMD_FREE, 24'd0, 32'd128);
        send(CMD_FREE, 24'd0, 32'd81);
        send(CMD_ALLOC, 24'hFF_FFFF, 32'd0);
        send(CMD_ALLOC, 24'hFF_FFF1, 32'd0);
        drain();
        write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
        send(CMD_ALLOC, 24'd64, 32'd0);
        send(CMD_FREE, 24'd0, 32'h0000_0010);
        drain();
        write_reg(REG_HEAP_LIMIT, 32'd0);
        send(CMD_ALLOC, 24'hFF_FFFF, 32'd0);
        send(CMD_ALLOC, 24'd1, 32'd0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: bval = 32'd0;
                1: bval = 32'hFFFF_FFF0;
                2: bval = $urandom & 32'hFFFF_FFF0;
                default: bval = $urandom;
            endcase
            case (ph)
                0, 4: lval = 32'hFFFF_FFFF;
                1: lval = 32'd0;
                2, 6: lval = bval + 32'($urandom_range(256, 8192));
                default: lval = $urandom;
            endcase
            write_reg(REG_HEAP_BASE, bval);
            write_reg(REG_HEAP_LIMIT, lval);
            calm = (ph == 3 || ph == 6);
            for (int n = 0; n < 235; n++) begin
                random_request((ph == 4) ? 90 : 58);
                q = $urandom_range(0, 299);
                if (q == 0) drain();
            end
            drain();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_datapath.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
dv/ffha_tb_pkg.sv
dv/heap_scoreboard.sv
dv/tb.sv
